// ===== rtl/core/fpm_pkg.sv =====
// Shared types and constants for the half-precision multiplier.
package fpm_pkg;
  localparam logic [15:0] QNAN = 16'h7FFF;
  localparam logic [14:0] INF_MAG = 15'h7C00;
  localparam logic [6:0] BIAS = 7'd15;

  typedef struct packed {
    logic [15:0] product;
    logic        overflow_flag;
    logic        zero_flag;
    logic        nan_flag;
    logic        underflow_flag;
  } res_t;

  typedef struct packed {
    logic [15:0] operand_a;
    logic [15:0] operand_b;
  } ops_t;
endpackage

// ===== rtl/core/fpm_if.sv =====
// Valid/ready channel interfaces for operands and results.
interface fpm_in_if;
  logic                valid;
  logic                ready;
  fpm_pkg::ops_t       data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fpm_out_if;
  logic                valid;
  logic                ready;
  fpm_pkg::res_t       data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fp16_multiplier_truncating_core.sv =====
// Half-precision multiplier, truncating, with overflow/zero/nan/underflow flags.
// Pipeline: decode, multiply and output stages from input transfer to result valid.
// Throughput: one operand pair per cycle while the output channel is not stalled.
// A stall freezes all three stages together; the pipeline holds every item.
// Reset (rst_n, synchronous) clears the stage valid bits only.
module fp16_multiplier_truncating_core (
  input logic clk,
  input logic rst_n,
  fpm_in_if.sink   in_ch,
  fpm_out_if.source out_ch
);
  import fpm_pkg::*;

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: decode
  logic v1_r;
  logic s1_r, spec1_r;
  res_t spec_res1_r;
  logic [10:0] ma1_r, mb1_r;
  logic signed [6:0] e1_r;

  // stage 2: multiply
  logic v2_r;
  logic s2_r, spec2_r;
  res_t spec_res2_r;
  logic [21:0] mp2_r;
  logic signed [6:0] e2_r;

  // stage 3: output
  logic v3_r;
  res_t res3_r;

  logic [15:0] a, b;
  logic sa, sb, sg;
  logic [4:0] ea, eb;
  logic [9:0] fa, fb;
  logic a_inf, b_inf, a_nan, b_nan, a_zero, b_zero;
  res_t spec_nxt;
  logic spec_is;

  always_comb begin
    a = in_ch.data.operand_a;
    b = in_ch.data.operand_b;
    sa = a[15]; sb = b[15]; sg = sa ^ sb;
    ea = a[14:10]; eb = b[14:10];
    fa = a[9:0]; fb = b[9:0];
    a_inf = (ea == 5'd31) && (fa == '0);
    b_inf = (eb == 5'd31) && (fb == '0);
    a_nan = (ea == 5'd31) && (fa != '0);
    b_nan = (eb == 5'd31) && (fb != '0);
    a_zero = (ea == '0) && (fa == '0);
    b_zero = (eb == '0) && (fb == '0);
    spec_nxt = '0;
    spec_is = 1'b1;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      spec_nxt.product = QNAN;
      spec_nxt.nan_flag = 1'b1;
    end else if (a_inf || b_inf) begin
      spec_nxt.product = {sg, INF_MAG};
      spec_nxt.overflow_flag = 1'b1;
    end else if (a_zero || b_zero) begin
      spec_nxt.product = {sg, 15'd0};
      spec_nxt.zero_flag = 1'b1;
    end else begin
      spec_is = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid; v2_r <= v1_r; v3_r <= v2_r;
    end
  end

  logic [21:0] mp_n;
  logic signed [6:0] e_n, sh_e;
  logic [21:0] mp_s;
  logic [3:0] sh;
  res_t r_nxt;

  always_comb begin
    if (mp2_r[21]) begin
      mp_n = {1'b0, mp2_r[21:1]};
      e_n = e2_r + 7'sd1;
    end else begin
      mp_n = mp2_r;
      e_n = e2_r;
    end
    sh_e = 7'sd1 - e_n;
    sh = sh_e[3:0];
    mp_s = mp_n >> sh;
    r_nxt = '0;
    if (spec2_r) begin
      r_nxt = spec_res2_r;
    end else if (e_n >= 7'sd31) begin
      r_nxt.product = {s2_r, INF_MAG};
      r_nxt.overflow_flag = 1'b1;
    end else if (e_n < -7'sd10) begin
      r_nxt.product = {s2_r, 15'd0};
      r_nxt.zero_flag = 1'b1;
      r_nxt.underflow_flag = 1'b1;
    end else if (e_n <= 7'sd0) begin
      r_nxt.product = {s2_r, 5'd0, mp_s[19:10]};
      r_nxt.zero_flag = (mp_s == '0);
    end else begin
      r_nxt.product = {s2_r, e_n[4:0], mp_n[19:10]};
    end
    if (r_nxt.product[14:0] == '0) r_nxt.zero_flag = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= sg;
      spec1_r <= spec_is;
      spec_res1_r <= spec_nxt;
      ma1_r <= (ea == '0) ? {1'b0, fa} : {1'b1, fa};
      mb1_r <= (eb == '0) ? {1'b0, fb} : {1'b1, fb};
      e1_r <= $signed({2'b0, (ea == '0) ? 5'd1 : ea})
            + $signed({2'b0, (eb == '0) ? 5'd1 : eb}) - $signed(BIAS);
      s2_r <= s1_r;
      spec2_r <= spec1_r;
      spec_res2_r <= spec_res1_r;
      mp2_r <= {11'd0, ma1_r} * {11'd0, mb1_r};
      e2_r <= e1_r;
      res3_r <= r_nxt;
    end
  end

  assign out_ch.valid = v3_r;
  assign out_ch.data = res3_r;
endmodule

// ===== verif/fp16_multiplier_truncating_core_test.sv =====
// Self-checking testbench for the truncating half-precision multiplier core.
`timescale 1ns / 100ps

module fp16_multiplier_truncating_core_test;
  import fpm_pkg::*;

  localparam int NUM_RANDOM  = 1830;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 10;

  class product_scoreboard;
    res_t pending_products[$];
    int   errors;
    int   checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // Compute the truncated binary16 product and its flags.
    function res_t multiply(logic [15:0] a, logic [15:0] b);
      res_t        r;
      logic        sgn;
      logic [4:0]  ea, eb;
      logic [9:0]  fa, fb;
      logic        a_inf, b_inf, a_nan, b_nan, a_zero, b_zero;
      logic [10:0] ma, mb;
      logic [21:0] mp;
      int          e;
      sgn = a[15] ^ b[15];
      ea = a[14:10]; eb = b[14:10];
      fa = a[9:0];   fb = b[9:0];
      a_inf = (ea == 5'd31) && (fa == 0);
      b_inf = (eb == 5'd31) && (fb == 0);
      a_nan = (ea == 5'd31) && (fa != 0);
      b_nan = (eb == 5'd31) && (fb != 0);
      a_zero = (ea == 0) && (fa == 0);
      b_zero = (eb == 0) && (fb == 0);
      r = '0;
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
        r.product  = QNAN;
        r.nan_flag = 1'b1;
      end else if (a_inf || b_inf) begin
        r.product       = {sgn, INF_MAG};
        r.overflow_flag = 1'b1;
      end else if (a_zero || b_zero) begin
        r.product = {sgn, 15'd0};
      end else begin
        ma = (ea == 0) ? {1'b0, fa} : {1'b1, fa};
        mb = (eb == 0) ? {1'b0, fb} : {1'b1, fb};
        e  = ((ea == 0) ? 1 : int'(ea)) + ((eb == 0) ? 1 : int'(eb)) - 15;
        mp = 22'(ma) * 22'(mb);
        if (mp[21]) begin
          mp = mp >> 1;
          e++;
        end
        if (e >= 31) begin
          r.product       = {sgn, INF_MAG};
          r.overflow_flag = 1'b1;
        end else if (e < -10) begin
          r.product        = {sgn, 15'd0};
          r.underflow_flag = 1'b1;
        end else if (e <= 0) begin
          mp = mp >> (1 - e);
          r.product   = {sgn, 5'd0, mp[19:10]};
          r.zero_flag = (mp == 0);
        end else begin
          r.product = {sgn, 5'(e), mp[19:10]};
        end
      end
      if (r.product[14:0] == 0) r.zero_flag = 1'b1;
      return r;
    endfunction

    function void note_operands(ops_t ops);
      pending_products = {pending_products, multiply(ops.operand_a, ops.operand_b)};
    endfunction

    function void check_product(res_t got);
      res_t want;
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_products.pop_front();
      checked++;
      if (got.product !== want.product) begin
        $display("%0t: product expected %h actual %h", $time, want.product, got.product);
        errors++;
      end
      if (got.overflow_flag !== want.overflow_flag) begin
        $display("%0t: overflow expected %b actual %b", $time,
                 want.overflow_flag, got.overflow_flag);
        errors++;
      end
      if (got.zero_flag !== want.zero_flag) begin
        $display("%0t: zero expected %b actual %b", $time, want.zero_flag, got.zero_flag);
        errors++;
      end
      if (got.nan_flag !== want.nan_flag) begin
        $display("%0t: nan expected %b actual %b", $time, want.nan_flag, got.nan_flag);
        errors++;
      end
      if (got.underflow_flag !== want.underflow_flag) begin
        $display("%0t: underflow expected %b actual %b", $time,
                 want.underflow_flag, got.underflow_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  bit   quiet_tail;
  bit   long_holdoff;
  int   sent_count;

  fpm_in_if  in_ch();
  fpm_out_if out_ch();

  product_scoreboard sb;

  fp16_multiplier_truncating_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    quiet_tail   = 1'b0;
    long_holdoff = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Note transfers on both channels.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_operands(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_product(out_ch.data);
  end

  // Receiver: random stall bursts, one long hold-off, none in the tail.
  initial begin
    int n;
    cycle_count = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_holdoff) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        long_holdoff = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 20);
        out_ch.ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_pair(logic [15:0] a, logic [15:0] b);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{operand_a: a, operand_b: b};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  function automatic logic [15:0] random_half();
    logic [4:0] e;
    case ($urandom_range(0, 9))
      0: e = 5'd0;
      1: e = 5'd31;
      2: e = 5'($urandom_range(1, 6));
      3: e = 5'($urandom_range(25, 30));
      default: e = 5'($urandom_range(1, 30));
    endcase
    return {1'($urandom), e, ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom)};
  endfunction

  initial begin
    logic [15:0] corner[12];
    corner = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFFFF,
               16'h0001, 16'h83FF, 16'h3C00, 16'hBBFF, 16'h7BFF, 16'h0400};
    sent_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed corners: specials, extremes, subnormals, overflow, underflow.
    for (int i = 0; i < 12; i++) send_pair(corner[i], corner[(i * 5 + 3) % 12]);
    send_pair(16'h7C00, 16'h0000);
    send_pair(16'h8000, 16'hFC00);
    send_pair(16'h7BFF, 16'h7BFF);
    send_pair(16'h0001, 16'h0001);
    send_pair(16'h0400, 16'h3800);
    send_pair(16'h0400, 16'h1000);
    send_pair(16'h03FF, 16'h3FFF);
    send_pair(16'h3FFF, 16'hBFFF);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 400) long_holdoff = 1'b1;
      if (i == NUM_RANDOM - 200) quiet_tail = 1'b1;
      if ($urandom_range(0, 19) == 0)
        send_pair(16'($urandom), 16'($urandom));
      else
        send_pair(random_half(), random_half());
    end
    in_ch.valid <= 1'b0;
    while (sb.pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d operand pairs, checked %0d products incl. NaN/inf/zero/subnormal cases",
             sent_count, sb.checked);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/fpm_pkg.sv
rtl/core/fpm_if.sv
rtl/core/fp16_multiplier_truncating_core.sv
verif/fp16_multiplier_truncating_core_test.sv
